### rtl/core/tcf_pkg.sv
// Package for the touch coordinate filter: types, register map and constants.
`default_nettype none
package tcf_pkg;

  localparam int unsigned RAW_W  = 12;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned LED_W  = 8;
  localparam int unsigned THR_W  = 11;
  localparam int unsigned GRD_W  = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DIV_W  = 32;

  localparam logic [LED_W-1:0]  LED_FULL    = 8'd255;
  localparam logic [RAW_W-1:0]  SIZE_CAP    = 12'd2048;
  localparam logic [POS_W-1:0]  POS_MAX     = 11'd2047;

  // LED dimming: one step per 10 ms, fully dark after 255 steps
  localparam logic [TIME_W-1:0] DIM_SAT_MS  = 32'd2550;
  // x/10 == (x * 52429) >> 19 for every x below 2550
  localparam logic [15:0]       DIM_RECIP   = 16'd52429;
  localparam int unsigned       DIM_SHIFT   = 19;

  localparam logic [RAW_W-1:0]  X_MIN_RST  = 12'd150;
  localparam logic [RAW_W-1:0]  X_MAX_RST  = 12'd3784;
  localparam logic [RAW_W-1:0]  Y_MIN_RST  = 12'd277;
  localparam logic [RAW_W-1:0]  Y_MAX_RST  = 12'd3784;
  localparam logic [RAW_W-1:0]  WIDTH_RST  = 12'd800;
  localparam logic [RAW_W-1:0]  HEIGHT_RST = 12'd480;
  localparam logic [THR_W-1:0]  THR_RST    = 11'd12;
  localparam logic [GRD_W-1:0]  GUARD_RST  = 16'd40;

  typedef enum logic [2:0] {
    REG_X_MIN  = 3'd0,
    REG_X_MAX  = 3'd1,
    REG_Y_MIN  = 3'd2,
    REG_Y_MAX  = 3'd3,
    REG_WIDTH  = 3'd4,
    REG_HEIGHT = 3'd5,
    REG_THR    = 3'd6,
    REG_GUARD  = 3'd7
  } tcf_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP,
    ST_PEN,
    ST_LED,
    ST_MED,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_CLAMP,
    ST_FIN,
    ST_OUT
  } tcf_state_e;

endpackage
`default_nettype wire

### rtl/core/touch_coordinate_filter_unit.sv
// Touch coordinate filter: burst median, calibration mapping, EMA smoothing, release guard.
`default_nettype none
// Takes one pen word at a time (in_stall_o is high while a word is being worked on) and
// gives exactly one result word per input word through an output register. A pen-up poll
// or a pen-down sample that does not end a burst goes straight on to the output state; the
// first sample of a burst while already touching first passes the LED dimming step (a
// reciprocal multiply for elapsed/10). The sample that ends a burst then runs the median
// search over the rotating burst registers, the two calibration divides, the clamp and the
// smoothing step. Both calibration divides share one restoring divider that retires one
// quotient bit per cycle. A stalled output holds the block for as long as the stall lasts.
module touch_coordinate_filter_unit
  import tcf_pkg::*;
#(
  parameter int unsigned SAMPLES = 5
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               contact_i,
  input  wire logic [RAW_W-1:0]   x_sample_i,
  input  wire logic [RAW_W-1:0]   y_sample_i,
  input  wire logic [TIME_W-1:0]  now_ms_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    report_valid_o,
  output logic                    tip_down_o,
  output logic [POS_W-1:0]        x_pos_o,
  output logic [POS_W-1:0]        y_pos_o,
  output logic [LED_W-1:0]        led_level_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready
);

  localparam int unsigned CW = $clog2(SAMPLES + 1);
  localparam int unsigned IW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam logic [CW-1:0] N_C    = CW'(SAMPLES);
  localparam logic [CW-1:0] HALF_C = CW'(SAMPLES / 2);
  localparam logic [IW-1:0] LAST_C = IW'(SAMPLES - 1);

  tcf_state_e state_q, state_d;

  // configuration
  logic [RAW_W-1:0] x_min_q, x_max_q, y_min_q, y_max_q, width_q, height_q;
  logic [THR_W-1:0] thr_q;
  logic [GRD_W-1:0] guard_q;

  // control state
  logic              touching_q, pending_q, sv_q, rvld_q;
  logic [TIME_W-1:0] t_start_q, r_start_q;
  logic [CW-1:0]     bc_q;
  logic [LED_W-1:0]  led_q;
  logic [POS_W-1:0]  sx_q, sy_q, rx_q, ry_q;
  logic              full_q, axis_q;
  logic [CW-1:0]     mcnt_q;
  logic [IW-1:0]     cidx_q;
  logic [5:0]        dcnt_q;
  logic              out_valid_q;

  // payload
  logic [RAW_W-1:0]  xin_q, yin_q;
  logic [TIME_W-1:0] now_q;
  logic [RAW_W-1:0]  bx_q [SAMPLES];
  logic [RAW_W-1:0]  by_q [SAMPLES];
  logic [RAW_W-1:0]  cx_q, cy_q, medx_q, medy_q;
  logic [CW-1:0]     ltx_q, lex_q, lty_q, ley_q;
  logic signed [25:0] prod_q;
  logic              neg_q, zero_q;
  logic [DIV_W-1:0]  dq_q;
  logic [RAW_W-1:0]  rem_q, dvs_q;
  logic [POS_W-1:0]  mx_q, my_q;
  logic              res_rv_q, res_tip_q;
  logic [POS_W-1:0]  res_x_q, res_y_q;
  logic              o_rv_q, o_tip_q;
  logic [POS_W-1:0]  o_x_q, o_y_q;
  logic [LED_W-1:0]  o_led_q;

  // handshake / sequencer outputs
  logic in_acc, out_acc, out_load, cfg_wr;

  // ---------------- combinational datapath ----------------
  logic [CW-1:0] bc_eff, bc_new;
  logic          dim_go, burst_full;
  assign bc_eff     = (bc_q >= N_C) ? '0 : bc_q;
  assign bc_new     = bc_eff + CW'(1);
  assign burst_full = (bc_new == N_C);
  assign dim_go     = (bc_eff == '0) && touching_q;

  // LED dimming: only elapsed times below the saturation point need the quotient
  logic [TIME_W-1:0] elapsed;
  logic [27:0]       dim_prod;
  logic [LED_W-1:0]  dim_steps;
  assign elapsed   = now_q - t_start_q;
  assign dim_prod  = elapsed[RAW_W-1:0] * DIM_RECIP;
  assign dim_steps = dim_prod[DIM_SHIFT +: LED_W];

  // median: compare tap 0 against the held candidate
  logic [CW-1:0] ltx_n, lex_n, lty_n, ley_n;
  logic          med_last;
  assign ltx_n = ltx_q + CW'(bx_q[0] <  cx_q);
  assign lex_n = lex_q + CW'(bx_q[0] <= cx_q);
  assign lty_n = lty_q + CW'(by_q[0] <  cy_q);
  assign ley_n = ley_q + CW'(by_q[0] <= cy_q);
  assign med_last = (mcnt_q == N_C) && (cidx_q == LAST_C);

  // mapping operands for the axis in work
  logic [RAW_W-1:0]  m_raw, m_lo, m_hi, m_size;
  logic signed [12:0] m_diff, m_range;
  logic signed [25:0] m_prod;
  logic [25:0]       prod_abs;
  logic [12:0]       range_abs;
  logic [POS_W-1:0]  m_limit, m_pos;
  assign m_raw  = axis_q ? medy_q  : medx_q;
  assign m_lo   = axis_q ? y_min_q : x_min_q;
  assign m_hi   = axis_q ? y_max_q : x_max_q;
  assign m_size = axis_q ? height_q : width_q;
  assign m_diff  = $signed({1'b0, m_raw}) - $signed({1'b0, m_lo});
  assign m_range = $signed({1'b0, m_hi})  - $signed({1'b0, m_lo});
  assign m_prod  = m_diff * $signed({1'b0, m_size});
  assign prod_abs  = prod_q[25] ? 26'(-prod_q) : 26'(prod_q);
  assign range_abs = m_range[12] ? 13'(-m_range) : 13'(m_range);
  assign m_limit = (m_size >= SIZE_CAP) ? POS_MAX : POS_W'(m_size - 12'd1);
  assign m_pos = (zero_q || neg_q) ? '0 :
                 (dq_q > DIV_W'(m_limit)) ? m_limit : dq_q[POS_W-1:0];

  // one restoring divide step
  logic [12:0] rem_sh;
  logic        q_bit;
  assign rem_sh = {rem_q, dq_q[DIV_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, dvs_q});

  // EMA and jitter test
  logic [13:0]      sum_x, sum_y;
  logic [POS_W-1:0] ex, ey, adx, ady;
  logic             moved;
  assign sum_x = ({3'b0, mx_q} << 1) + {3'b0, mx_q} + ({3'b0, sx_q} << 2) + {3'b0, sx_q};
  assign sum_y = ({3'b0, my_q} << 1) + {3'b0, my_q} + ({3'b0, sy_q} << 2) + {3'b0, sy_q};
  assign ex  = sv_q ? sum_x[13:3] : mx_q;
  assign ey  = sv_q ? sum_y[13:3] : my_q;
  assign adx = (ex > rx_q) ? ex - rx_q : rx_q - ex;
  assign ady = (ey > ry_q) ? ey - ry_q : ry_q - ey;
  assign moved = !rvld_q || (adx >= thr_q) || (ady >= thr_q);

  // release guard
  logic [TIME_W-1:0] rel_start;
  logic              rel_done;
  assign rel_start = pending_q ? r_start_q : now_q;
  assign rel_done  = (now_q - rel_start) >= TIME_W'(guard_q);

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = contact_i ? ST_PEN : ST_UP;
      ST_UP:    state_d = ST_OUT;
      ST_PEN: begin
        if (dim_go) state_d = ST_LED;
        else        state_d = burst_full ? ST_MED : ST_OUT;
      end
      ST_DIV:   if (dcnt_q == 6'(DIV_W - 1)) state_d = ST_CLAMP;
      ST_LED:   state_d = full_q ? ST_MED : ST_OUT;
      ST_MED:   if (med_last) state_d = ST_MUL;
      ST_MUL:   state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_DIV;
      ST_CLAMP: state_d = axis_q ? ST_FIN : ST_MUL;
      ST_FIN:   state_d = ST_OUT;
      ST_OUT:   if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    in_acc     = in_valid_i && (state_q == ST_IDLE);
    out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
    out_acc    = out_valid_q && !out_stall_i;
    cfg_wr     = psel && penable && pwrite;
    pready     = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q  <= X_MIN_RST;
      x_max_q  <= X_MAX_RST;
      y_min_q  <= Y_MIN_RST;
      y_max_q  <= Y_MAX_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      thr_q    <= THR_RST;
      guard_q  <= GUARD_RST;
    end else if (cfg_wr) begin
      unique case (tcf_reg_e'(paddr[4:2]))
        REG_X_MIN:  x_min_q  <= pwdata[RAW_W-1:0];
        REG_X_MAX:  x_max_q  <= pwdata[RAW_W-1:0];
        REG_Y_MIN:  y_min_q  <= pwdata[RAW_W-1:0];
        REG_Y_MAX:  y_max_q  <= pwdata[RAW_W-1:0];
        REG_WIDTH:  width_q  <= pwdata[RAW_W-1:0];
        REG_HEIGHT: height_q <= pwdata[RAW_W-1:0];
        REG_THR:    thr_q    <= pwdata[THR_W-1:0];
        REG_GUARD:  guard_q  <= pwdata[GRD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (tcf_reg_e'(paddr[4:2]))
      REG_X_MIN:  prdata = DATA_W'(x_min_q);
      REG_X_MAX:  prdata = DATA_W'(x_max_q);
      REG_Y_MIN:  prdata = DATA_W'(y_min_q);
      REG_Y_MAX:  prdata = DATA_W'(y_max_q);
      REG_WIDTH:  prdata = DATA_W'(width_q);
      REG_HEIGHT: prdata = DATA_W'(height_q);
      REG_THR:    prdata = DATA_W'(thr_q);
      REG_GUARD:  prdata = DATA_W'(guard_q);
      default:    prdata = '0;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touching_q  <= 1'b0;
      pending_q   <= 1'b0;
      sv_q        <= 1'b0;
      rvld_q      <= 1'b0;
      t_start_q   <= '0;
      r_start_q   <= '0;
      bc_q        <= '0;
      led_q       <= LED_FULL;
      sx_q        <= '0;
      sy_q        <= '0;
      rx_q        <= '0;
      ry_q        <= '0;
      full_q      <= 1'b0;
      axis_q      <= 1'b0;
      mcnt_q      <= '0;
      cidx_q      <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load)     out_valid_q <= 1'b1;
      else if (out_acc) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_UP: begin
          bc_q <= '0;
          if (touching_q) begin
            pending_q <= !rel_done;
            r_start_q <= rel_start;
            if (rel_done) begin
              touching_q <= 1'b0;
              sv_q       <= 1'b0;
              rvld_q     <= 1'b0;
              led_q      <= LED_FULL;
            end
          end
        end
        ST_PEN: begin
          pending_q <= 1'b0;
          if ((bc_eff == '0) && !touching_q) begin
            touching_q <= 1'b1;
            t_start_q  <= now_q;
            sv_q       <= 1'b0;
            rvld_q     <= 1'b0;
            led_q      <= '0;
          end
          bc_q      <= burst_full ? '0 : bc_new;
          full_q    <= burst_full;
          axis_q    <= 1'b0;
          mcnt_q    <= '0;
          cidx_q    <= '0;
          dcnt_q    <= '0;
        end
        ST_DIV: dcnt_q <= dcnt_q + 6'd1;
        ST_LED: begin
          led_q <= (elapsed >= DIM_SAT_MS) ? '0 : LED_FULL - dim_steps;
        end
        ST_MED: begin
          if (mcnt_q == N_C) begin
            mcnt_q <= '0;
            cidx_q <= cidx_q + IW'(1);
          end else begin
            mcnt_q <= mcnt_q + CW'(1);
          end
        end
        ST_LOAD: dcnt_q <= '0;
        ST_CLAMP: axis_q <= 1'b1;
        ST_FIN: begin
          sx_q <= ex;
          sy_q <= ey;
          sv_q <= 1'b1;
          if (moved) begin
            rvld_q <= 1'b1;
            rx_q   <= ex;
            ry_q   <= ey;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      xin_q <= x_sample_i;
      yin_q <= y_sample_i;
      now_q <= now_ms_i;
    end
    if (out_load) begin
      o_rv_q  <= res_rv_q;
      o_tip_q <= res_tip_q;
      o_x_q   <= res_x_q;
      o_y_q   <= res_y_q;
      o_led_q <= led_q;
    end

    unique case (state_q)
      ST_UP: begin
        res_rv_q  <= touching_q && rel_done;
        res_tip_q <= 1'b0;
        res_x_q   <= '0;
        res_y_q   <= '0;
      end
      ST_PEN: begin
        for (int i = 0; i < SAMPLES - 1; i++) begin
          bx_q[i] <= bx_q[i+1];
          by_q[i] <= by_q[i+1];
        end
        bx_q[SAMPLES-1] <= xin_q;
        by_q[SAMPLES-1] <= yin_q;
        res_rv_q  <= 1'b0;
        res_tip_q <= 1'b0;
        res_x_q   <= '0;
        res_y_q   <= '0;
      end
      ST_MED: begin
        // rotate the burst past the candidate; the extra rotation brings up the next one
        for (int i = 0; i < SAMPLES - 1; i++) begin
          bx_q[i] <= bx_q[i+1];
          by_q[i] <= by_q[i+1];
        end
        bx_q[SAMPLES-1] <= bx_q[0];
        by_q[SAMPLES-1] <= by_q[0];
        if (mcnt_q == '0) begin
          cx_q  <= bx_q[0];
          cy_q  <= by_q[0];
          ltx_q <= '0;
          lex_q <= '0;
          lty_q <= '0;
          ley_q <= '0;
        end else begin
          ltx_q <= ltx_n;
          lex_q <= lex_n;
          lty_q <= lty_n;
          ley_q <= ley_n;
          if (mcnt_q == N_C) begin
            if ((ltx_n <= HALF_C) && (lex_n > HALF_C)) medx_q <= cx_q;
            if ((lty_n <= HALF_C) && (ley_n > HALF_C)) medy_q <= cy_q;
          end
        end
      end
      ST_MUL: prod_q <= m_prod;
      ST_LOAD: begin
        dq_q   <= DIV_W'(prod_abs);
        dvs_q  <= range_abs[RAW_W-1:0];
        rem_q  <= '0;
        neg_q  <= prod_q[25] ^ m_range[12];
        zero_q <= (m_size == '0) || (m_range == '0);
      end
      ST_DIV: begin
        rem_q <= q_bit ? RAW_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[RAW_W-1:0];
        dq_q  <= {dq_q[DIV_W-2:0], q_bit};
      end
      ST_CLAMP: begin
        if (axis_q) my_q <= m_pos;
        else        mx_q <= m_pos;
      end
      ST_FIN: begin
        res_rv_q  <= moved;
        res_tip_q <= moved;
        res_x_q   <= moved ? ex : '0;
        res_y_q   <= moved ? ey : '0;
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign report_valid_o = o_rv_q;
  assign tip_down_o     = o_tip_q;
  assign x_pos_o        = o_x_q;
  assign y_pos_o        = o_y_q;
  assign led_level_o    = o_led_q;

`ifndef ASSERT_OFF
  a_no_report_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !report_valid_o |-> !tip_down_o && x_pos_o == '0 && y_pos_o == '0)
    else $error("word without report carries position data");

  a_release_led: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && report_valid_o && !tip_down_o |-> led_level_o == LED_FULL
      && x_pos_o == '0 && y_pos_o == '0)
    else $error("release report with stale position or dimmed LED");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV && !zero_q |-> dvs_q != '0)
    else $error("divider running on a zero divisor");

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MED || state_q == ST_DIV |-> in_stall_o && !out_load)
    else $error("input taken or result loaded mid computation");
`endif

endmodule
`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for touch_coordinate_filter_unit: random pen words against a predictor.
`default_nettype none
module tb_top;
  import tcf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BURST_LEN = 5;

  typedef struct {
    logic              pen;
    logic [RAW_W-1:0]  x;
    logic [RAW_W-1:0]  y;
    logic [TIME_W-1:0] t;
  } pen_word_t;

  typedef struct {
    logic             rv;
    logic             tip;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [LED_W-1:0] led;
  } report_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              contact = 1'b0;
  logic [RAW_W-1:0]  x_sample = '0;
  logic [RAW_W-1:0]  y_sample = '0;
  logic [TIME_W-1:0] now_ms = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              report_valid, tip_down;
  logic [POS_W-1:0]  x_pos, y_pos;
  logic [LED_W-1:0]  led_level;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  touch_coordinate_filter_unit #(.SAMPLES(BURST_LEN)) i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .contact_i(contact), .x_sample_i(x_sample), .y_sample_i(y_sample), .now_ms_i(now_ms),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .report_valid_o(report_valid), .tip_down_o(tip_down),
    .x_pos_o(x_pos), .y_pos_o(y_pos), .led_level_o(led_level),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // calibration copy, updated as registers are written
  logic [RAW_W-1:0] cal_x_min = X_MIN_RST, cal_x_max = X_MAX_RST;
  logic [RAW_W-1:0] cal_y_min = Y_MIN_RST, cal_y_max = Y_MAX_RST;
  logic [RAW_W-1:0] cal_width = WIDTH_RST, cal_height = HEIGHT_RST;
  logic [THR_W-1:0] cal_thr = THR_RST;
  logic [GRD_W-1:0] cal_guard = GUARD_RST;

  // filter state
  logic              f_touching = 1'b0, f_rel_pend = 1'b0;
  logic [TIME_W-1:0] f_touch_t = '0, f_rel_t = '0;
  int unsigned       f_count = 0;
  logic [RAW_W-1:0]  f_xb [BURST_LEN];
  logic [RAW_W-1:0]  f_yb [BURST_LEN];
  logic              f_sm_ok = 1'b0, f_rep_ok = 1'b0;
  logic [POS_W-1:0]  f_sm_x = '0, f_sm_y = '0, f_rep_x = '0, f_rep_y = '0;
  logic [LED_W-1:0]  f_led = LED_FULL;

  pen_word_t   pending_words[$];
  report_t     expected_reports[$];
  int          errors = 0;
  logic [TIME_W-1:0] clock_ms = '0;

  function automatic logic [RAW_W-1:0] burst_median(logic [RAW_W-1:0] v [BURST_LEN]);
    logic [RAW_W-1:0] s [BURST_LEN];
    logic [RAW_W-1:0] tmp;
    s = v;
    for (int i = 0; i < BURST_LEN; i++)
      for (int j = 0; j < BURST_LEN - 1 - i; j++)
        if (s[j] > s[j+1]) begin
          tmp = s[j]; s[j] = s[j+1]; s[j+1] = tmp;
        end
    return s[BURST_LEN/2];
  endfunction

  function automatic logic [POS_W-1:0] raw_to_pixel(logic [RAW_W-1:0] raw, logic [RAW_W-1:0] lo,
                                                    logic [RAW_W-1:0] hi, logic [RAW_W-1:0] size);
    longint rng, lim, pos;
    rng = longint'(hi) - longint'(lo);
    if (size == 0 || rng == 0) return '0;
    lim = (size > 2048 ? 2048 : longint'(size)) - 1;
    pos = ((longint'(raw) - longint'(lo)) * longint'(size)) / rng;
    if (pos < 0) pos = 0;
    if (pos > lim) pos = lim;
    return pos[POS_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] smooth(logic [POS_W-1:0] s, logic [POS_W-1:0] old);
    int unsigned r;
    r = (3 * int'(s) + 5 * int'(old)) / 8;
    return r[POS_W-1:0];
  endfunction

  function automatic int unsigned dist_of(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
    return a > b ? a - b : b - a;
  endfunction

  task automatic filter_word(input pen_word_t w);
    report_t r;
    logic [TIME_W-1:0] steps;
    logic [POS_W-1:0] mx, my;
    r = '{rv: 1'b0, tip: 1'b0, x: '0, y: '0, led: '0};
    if (w.pen) begin
      f_rel_pend = 1'b0;
      if (f_count >= BURST_LEN) f_count = 0;
      if (f_count == 0) begin
        if (!f_touching) begin
          f_touching = 1'b1; f_touch_t = w.t;
          f_sm_ok = 1'b0; f_rep_ok = 1'b0; f_led = '0;
        end else begin
          steps = (w.t - f_touch_t) / 10;
          f_led = steps >= 255 ? 8'd0 : 8'(255 - steps);
        end
      end
      f_xb[f_count] = w.x;
      f_yb[f_count] = w.y;
      f_count++;
      if (f_count == BURST_LEN) begin
        f_count = 0;
        mx = raw_to_pixel(burst_median(f_xb), cal_x_min, cal_x_max, cal_width);
        my = raw_to_pixel(burst_median(f_yb), cal_y_min, cal_y_max, cal_height);
        f_sm_x = f_sm_ok ? smooth(mx, f_sm_x) : mx;
        f_sm_y = f_sm_ok ? smooth(my, f_sm_y) : my;
        f_sm_ok = 1'b1;
        if (!f_rep_ok || dist_of(f_sm_x, f_rep_x) >= cal_thr ||
            dist_of(f_sm_y, f_rep_y) >= cal_thr) begin
          f_rep_ok = 1'b1; f_rep_x = f_sm_x; f_rep_y = f_sm_y;
          r.rv = 1'b1; r.tip = 1'b1; r.x = f_sm_x; r.y = f_sm_y;
        end
      end
    end else begin
      f_count = 0;
      if (f_touching) begin
        if (!f_rel_pend) begin
          f_rel_pend = 1'b1; f_rel_t = w.t;
        end
        if (w.t - f_rel_t >= cal_guard) begin
          f_touching = 1'b0; f_sm_ok = 1'b0; f_rep_ok = 1'b0;
          f_rel_pend = 1'b0; f_led = LED_FULL; r.rv = 1'b1;
        end
      end
    end
    r.led = f_led;
    expected_reports.push_back(r);
  endtask

  // sender: bursts of words with random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall)
        filter_word('{pen: contact, x: x_sample, y: y_sample, t: now_ms});
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          pen_word_t w;
          w = pending_words.pop_front();
          contact <= w.pen; x_sample <= w.x; y_sample <= w.y; now_ms <= w.t;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, plus a long hold-off on request
  logic hold_req = 1'b0;
  int   hold_cnt = 0, mode_cnt = 0, stall_mode = 0;
  always @(posedge clk_i) begin
    if (mode_cnt == 0) begin
      mode_cnt <= $urandom_range(50, 400);
      stall_mode <= $urandom_range(0, 3);
    end else begin
      mode_cnt <= mode_cnt - 1;
    end
    if (hold_req && hold_cnt == 0) begin
      hold_cnt <= 600;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= (hold_cnt > 1);
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= ($urandom_range(0, 9) < 8);
        default: out_stall <= (mode_cnt % 3 == 0);
      endcase
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected word rv=%0b tip=%0b x=%0d y=%0d led=%0d", $time,
                 report_valid, tip_down, x_pos, y_pos, led_level);
        errors++;
      end else begin
        report_t e;
        e = expected_reports.pop_front();
        if (report_valid !== e.rv) begin
          $display("%0t: report_valid exp %0b got %0b", $time, e.rv, report_valid); errors++;
        end
        if (tip_down !== e.tip) begin
          $display("%0t: tip_down exp %0b got %0b", $time, e.tip, tip_down); errors++;
        end
        if (x_pos !== e.x) begin
          $display("%0t: x_pos exp %0d got %0d", $time, e.x, x_pos); errors++;
        end
        if (y_pos !== e.y) begin
          $display("%0t: y_pos exp %0d got %0d", $time, e.y, y_pos); errors++;
        end
        if (led_level !== e.led) begin
          $display("%0t: led_level exp %0d got %0d", $time, e.led, led_level); errors++;
        end
      end
    end
  end

  task automatic reg_write(input tcf_reg_e idx, input logic [DATA_W-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 2; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_X_MIN:  cal_x_min = val[RAW_W-1:0];
      REG_X_MAX:  cal_x_max = val[RAW_W-1:0];
      REG_Y_MIN:  cal_y_min = val[RAW_W-1:0];
      REG_Y_MAX:  cal_y_max = val[RAW_W-1:0];
      REG_WIDTH:  cal_width = val[RAW_W-1:0];
      REG_HEIGHT: cal_height = val[RAW_W-1:0];
      REG_THR:    cal_thr = val[THR_W-1:0];
      default:    cal_guard = val[GRD_W-1:0];
    endcase
  endtask

  task automatic write_all(input int xl, xh, yl, yh, w, h, thr, grd);
    reg_write(REG_X_MIN, xl);  reg_write(REG_X_MAX, xh);
    reg_write(REG_Y_MIN, yl);  reg_write(REG_Y_MAX, yh);
    reg_write(REG_WIDTH, w);   reg_write(REG_HEIGHT, h);
    reg_write(REG_THR, thr);   reg_write(REG_GUARD, grd);
  endtask

  task automatic add_word(input logic pen, input int x, input int y, input int unsigned dt);
    clock_ms += dt;
    pending_words.push_back('{pen: pen, x: RAW_W'(x), y: RAW_W'(y), t: clock_ms});
  endtask

  function automatic int clip_raw(int v);
    return v < 0 ? 0 : (v > 4095 ? 4095 : v);
  endfunction

  // one pen stroke: bursts around a wandering point, maybe broken, then usually a release
  task automatic add_stroke();
    int cx, cy, spread, nb;
    cx = $urandom_range(0, 4095); cy = $urandom_range(0, 4095);
    spread = $urandom_range(0, 3) == 0 ? 400 : 30;
    nb = $urandom_range(1, 6);
    for (int b = 0; b < nb; b++) begin
      if ($urandom_range(0, 2) == 0) begin
        cx = clip_raw(cx + $urandom_range(0, 600) - 300);
        cy = clip_raw(cy + $urandom_range(0, 600) - 300);
      end
      for (int s = 0; s < BURST_LEN; s++) begin
        if (b > 0 && s == 0 && $urandom_range(0, 5) == 0)
          add_word(1'b1, cx, cy, $urandom_range(1000, 4000));
        else
          add_word(1'b1, clip_raw(cx + $urandom_range(0, 2*spread) - spread),
                   clip_raw(cy + $urandom_range(0, 2*spread) - spread), $urandom_range(0, 12));
        if ($urandom_range(0, 40) == 0)
          add_word(1'b0, $urandom, $urandom, $urandom_range(0, 5));
      end
    end
    for (int k = $urandom_range(0, 3); k > 0; k--)
      add_word(1'b0, $urandom, $urandom, $urandom_range(0, 20));
    if ($urandom_range(0, 4) == 0) return;
    add_word(1'b0, $urandom, $urandom,
             $urandom_range(0, 1) ? cal_guard + $urandom_range(0, 3) : $urandom);
  endtask

  // sampled between edges so that all handshake updates have settled
  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || expected_reports.size() != 0)
      @(negedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic add_random_phase(input int n);
    int start;
    start = pending_words.size();
    while (pending_words.size() - start < n) begin
      if ($urandom_range(0, 9) == 0) begin
        clock_ms = $urandom;
        add_word($urandom_range(0, 1), $urandom, $urandom, 0);
      end else begin
        add_stroke();
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    // directed: idle pen-up, extremes, dimming, broken burst, cancelled and real release
    add_word(1'b0, 4095, 4095, 3);
    for (int s = 0; s < BURST_LEN; s++) add_word(1'b1, 0, 4095, 1);
    for (int s = 0; s < BURST_LEN; s++) add_word(1'b1, 4095, 0, 2);
    add_word(1'b1, 2000, 2000, 3000);
    for (int s = 1; s < BURST_LEN; s++) add_word(1'b1, 2000, 2000, 1);
    add_word(1'b1, 100, 100, 1); add_word(1'b1, 100, 100, 1);
    add_word(1'b0, 0, 0, 5);
    add_word(1'b1, 100, 100, 10);
    add_word(1'b0, 0, 0, 1);
    add_word(1'b0, 0, 0, 50);
    clock_ms = 32'hFFFF_FFF0;
    for (int s = 0; s < BURST_LEN; s++) add_word(1'b1, 1500, 2500, 1);
    for (int s = 0; s < BURST_LEN; s++) add_word(1'b1, 1500, 2500, 20);
    wait_drained();

    for (int ph = 1; ph <= 10; ph++) begin
      case (ph)
        1: write_all(0, 4095, 4095, 0, 2048, 4095, 0, 0);
        2: write_all(2000, 2000, 300, 3000, 0, 1, 2047, 65535);
        default: write_all($urandom_range(0, 4095), $urandom_range(0, 4095),
                           $urandom_range(0, 800), $urandom_range(3000, 4095),
                           $urandom_range(1, 2048), $urandom_range(1, 2048),
                           $urandom_range(0, 40), $urandom_range(0, 120));
      endcase
      @(negedge clk_i);
      add_random_phase(180);
      if (ph == 4 || ph == 8) begin
        repeat (20) @(negedge clk_i);
        hold_req = 1'b1;
        @(negedge clk_i);
        hold_req = 1'b0;
      end
      wait_drained();
    end

    if (errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    #30ms;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
rtl/core/tcf_pkg.sv
rtl/core/touch_coordinate_filter_unit.sv
sim/tb_top.sv
